// ===== design/cdac_pkg.sv =====
// Shared types, constants and the month-length table for the calendar date counter.
`default_nettype none

package cdac_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ADV_W   = 10;

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [ADV_W-1:0]   adv_t;
  typedef logic               op_t;

  // Request operation codes.
  localparam op_t OP_LOAD    = 1'b0;
  localparam op_t OP_ADVANCE = 1'b1;

  // Defaults for the top-level parameters.
  localparam int MAX_ADVANCE_DEF = 1023;
  localparam int YEAR_MAX_DEF    = 9999;

  // State after reset: 1 January 2000, which is a leap year.
  localparam day_t   RESET_DAY   = 5'd1;
  localparam month_t RESET_MONTH = 4'd1;
  localparam year_t  RESET_YEAR  = 14'd2000;
  localparam logic   RESET_LEAP  = 1'b1;

  localparam day_t   FIRST_DAY    = 5'd1;
  localparam month_t FIRST_MONTH  = 4'd1;
  localparam month_t FEBRUARY     = 4'd2;
  localparam month_t DECEMBER     = 4'd12;
  localparam day_t   LEAP_FEB_LEN = 5'd29;

  // Month lengths indexed by the raw month code; codes outside 1..12 have no days.
  localparam day_t MONTH_LEN [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  // Division of a year by 25 through a reciprocal: floor(y * 20972 / 2^19) is exact
  // for every 14-bit year.
  localparam int            RECIP_SHIFT = 19;
  localparam int            PROD_W      = 29;
  localparam int            QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [14:0]   RECIP_25    = 15'd20972;

  function automatic day_t days_in_month(month_t m, logic leap);
    day_t len;
    len = MONTH_LEN[m];
    if (m == FEBRUARY && leap) begin
      len = LEAP_FEB_LEN;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/cdac_req_if.sv =====
// Request channel of the calendar date counter: operation, reference date and day count.
`default_nettype none

interface cdac_req_if;
  logic            valid;
  logic            ready;
  cdac_pkg::op_t    op;
  cdac_pkg::day_t   day;
  cdac_pkg::month_t month;
  cdac_pkg::year_t  year;
  cdac_pkg::adv_t   advance_days;

  modport source (output valid, op, day, month, year, advance_days, input ready);
  modport sink   (input valid, op, day, month, year, advance_days, output ready);
endinterface

`default_nettype wire

// ===== design/cdac_rsp_if.sv =====
// Result channel of the calendar date counter: stored date and compare flags.
`default_nettype none

interface cdac_rsp_if;
  logic             valid;
  logic             ready;
  cdac_pkg::day_t   cur_day;
  cdac_pkg::month_t cur_month;
  cdac_pkg::year_t  cur_year;
  logic             is_before;
  logic             is_equal;
  logic             is_after;

  modport source (output valid, cur_day, cur_month, cur_year, is_before, is_equal, is_after,
                  input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, is_before, is_equal, is_after,
                  output ready);
endinterface

`default_nettype wire

// ===== design/cdac_leap.sv =====
// Leap-year unit: divides the year by 25 through a reciprocal multiply.
`default_nettype none

module cdac_leap (
  input  wire logic            clk_i,
  input  wire cdac_pkg::year_t year_i,
  output logic                 leap_o
);

  logic [cdac_pkg::PROD_W-1:0] prod_q;
  cdac_pkg::year_t             year_q;
  logic [cdac_pkg::QUOT_W-1:0] quot;
  cdac_pkg::year_t             quot_x25;
  cdac_pkg::year_t             rem;
  logic                        div25;

  always_ff @(posedge clk_i) begin
    prod_q <= cdac_pkg::PROD_W'(year_i) * cdac_pkg::PROD_W'(cdac_pkg::RECIP_25);
    year_q <= year_i;
  end

  // The remainder of year / 25 is zero exactly when year - 25 * quotient is zero.
  assign quot     = prod_q[cdac_pkg::PROD_W-1:cdac_pkg::RECIP_SHIFT];
  assign quot_x25 = cdac_pkg::YEAR_W'({quot, 4'b0000}) + cdac_pkg::YEAR_W'({quot, 3'b000})
                  + cdac_pkg::YEAR_W'(quot);
  assign rem      = year_q - quot_x25;
  assign div25    = (rem == '0);

  // Divisible by 4 but not 100, or divisible by 400 (that is, by 16 and by 25).
  assign leap_o = ((year_q[1:0] == 2'b00) && !div25) || ((year_q[3:0] == 4'b0000) && div25);

endmodule

`default_nettype wire

// ===== design/calendar_date_advance_compare.sv =====
// Top level of the Gregorian calendar date counter with date compare.
`default_nettype none

// Channel  Direction  Interface    Contents
// req_i    in         cdac_req_if  op, day, month, year, advance_days
// rsp_o    out        cdac_rsp_if  cur_day, cur_month, cur_year, is_before, is_equal, is_after
//
// A load request passes through ST_LEAP1, ST_LEAP2 and ST_RESULT before its result is valid:
// the leap flag of the new year is worked out by the reciprocal unit. An advance request runs
// the day stepper for the clamped day count; it advances one day per cycle, but leaves
// ST_STEP for ST_LEAP1 and ST_LEAP2 at each new year. Reset puts the date at 1 January 2000.
// req_i.ready is high only while the sequencer is idle; a result waiting in the output
// register does not hold off the next request, but a second finished result waits for it.

module calendar_date_advance_compare #(
  parameter int MAX_ADVANCE = cdac_pkg::MAX_ADVANCE_DEF,
  parameter int YEAR_MAX    = cdac_pkg::YEAR_MAX_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cdac_req_if.sink    req_i,
  cdac_rsp_if.source  rsp_o
);

  // Day counter width and the width used to clamp the requested count.
  localparam int CNT_W  = $clog2(MAX_ADVANCE + 1);
  localparam int CLP_W  = (CNT_W > cdac_pkg::ADV_W) ? CNT_W : cdac_pkg::ADV_W;
  localparam logic [CLP_W-1:0] ADV_LIMIT = CLP_W'(MAX_ADVANCE);

  // Width used to compare the year against the wrap limit.
  localparam int YCMP_W = ($clog2(YEAR_MAX + 1) > cdac_pkg::YEAR_W) ?
                          $clog2(YEAR_MAX + 1) : cdac_pkg::YEAR_W;
  localparam logic [YCMP_W-1:0] YEAR_LIMIT = YCMP_W'(YEAR_MAX);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LEAP1  = 3'd1;
  localparam logic [2:0] ST_LEAP2  = 3'd2;
  localparam logic [2:0] ST_STEP   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]       state_q, state_d;
  cdac_pkg::day_t   day_q, day_d;
  cdac_pkg::month_t month_q, month_d;
  cdac_pkg::year_t  year_q, year_d;
  logic             leap_q, leap_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rsp_valid_q, rsp_valid_d;

  // Request payload held for the duration of the request.
  cdac_pkg::op_t    op_q, op_d;
  cdac_pkg::day_t   ref_day_q, ref_day_d;
  cdac_pkg::month_t ref_month_q, ref_month_d;
  cdac_pkg::year_t  ref_year_q, ref_year_d;

  // Output register.
  cdac_pkg::day_t   out_day_q, out_day_d;
  cdac_pkg::month_t out_month_q, out_month_d;
  cdac_pkg::year_t  out_year_q, out_year_d;
  logic             out_before_q, out_before_d;
  logic             out_equal_q, out_equal_d;
  logic             out_after_q, out_after_d;

  logic             req_fire;
  logic             unit_leap;
  logic [CLP_W-1:0] adv_ext;
  logic [CLP_W-1:0] adv_clamped;

  cdac_pkg::day_t   dim;
  logic [cdac_pkg::DAY_W:0] day_inc;
  logic             month_end;
  logic             year_end;
  logic             at_limit;
  cdac_pkg::year_t  next_year;
  logic             cmp_before;
  logic             cmp_equal;

  cdac_leap u_leap (
    .clk_i  (clk_i),
    .year_i (year_q),
    .leap_o (unit_leap)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // The day count is limited to MAX_ADVANCE.
  assign adv_ext     = CLP_W'(req_i.advance_days);
  assign adv_clamped = (adv_ext > ADV_LIMIT) ? ADV_LIMIT : adv_ext;

  // Next-day logic. A month code outside one to twelve has no days, so any day rolls over.
  assign dim       = cdac_pkg::days_in_month(month_q, leap_q);
  assign day_inc   = {1'b0, day_q} + (cdac_pkg::DAY_W + 1)'(1);
  assign month_end = day_inc > {1'b0, dim};
  assign year_end  = month_q >= cdac_pkg::DECEMBER;
  assign at_limit  = YCMP_W'(year_q) >= YEAR_LIMIT;
  assign next_year = at_limit ? '0 : year_q + cdac_pkg::YEAR_W'(1);

  // Compare the stored date with the reference date: year, then month, then day.
  always_comb begin
    if (year_q != ref_year_q) begin
      cmp_before = year_q < ref_year_q;
    end else if (month_q != ref_month_q) begin
      cmp_before = month_q < ref_month_q;
    end else begin
      cmp_before = day_q < ref_day_q;
    end
  end
  assign cmp_equal = (day_q == ref_day_q) && (month_q == ref_month_q) && (year_q == ref_year_q);

  always_comb begin
    state_d      = state_q;
    day_d        = day_q;
    month_d      = month_q;
    year_d       = year_q;
    leap_d       = leap_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    ref_day_d    = ref_day_q;
    ref_month_d  = ref_month_q;
    ref_year_d   = ref_year_q;
    out_day_d    = out_day_q;
    out_month_d  = out_month_q;
    out_year_d   = out_year_q;
    out_before_d = out_before_q;
    out_equal_d  = out_equal_q;
    out_after_d  = out_after_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d        = req_i.op;
          ref_day_d   = req_i.day;
          ref_month_d = req_i.month;
          ref_year_d  = req_i.year;
          if (req_i.op == cdac_pkg::OP_LOAD) begin
            // Loaded dates are stored unchanged; only the leap flag must be refreshed.
            day_d   = req_i.day;
            month_d = req_i.month;
            year_d  = req_i.year;
            state_d = ST_LEAP1;
          end else begin
            cnt_d   = CNT_W'(adv_clamped);
            state_d = ST_STEP;
          end
        end
      end
      ST_LEAP1: begin
        state_d = ST_LEAP2;
      end
      ST_LEAP2: begin
        leap_d  = unit_leap;
        state_d = (op_q == cdac_pkg::OP_LOAD) ? ST_RESULT : ST_STEP;
      end
      ST_STEP: begin
        if (cnt_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          if (month_end) begin
            day_d = cdac_pkg::FIRST_DAY;
            if (year_end) begin
              // New year: recompute the leap flag before the next step.
              month_d = cdac_pkg::FIRST_MONTH;
              year_d  = next_year;
              state_d = ST_LEAP1;
            end else begin
              month_d = month_q + cdac_pkg::MONTH_W'(1);
            end
          end else begin
            day_d = day_inc[cdac_pkg::DAY_W-1:0];
          end
        end
      end
      ST_RESULT: begin
        // Wait until the output register is free or is being emptied this cycle.
        if (!rsp_valid_q || rsp_o.ready) begin
          out_day_d    = day_q;
          out_month_d  = month_q;
          out_year_d   = year_q;
          out_before_d = cmp_before;
          out_equal_d  = cmp_equal;
          out_after_d  = !cmp_before && !cmp_equal;
          rsp_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      day_q       <= cdac_pkg::RESET_DAY;
      month_q     <= cdac_pkg::RESET_MONTH;
      year_q      <= cdac_pkg::RESET_YEAR;
      leap_q      <= cdac_pkg::RESET_LEAP;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      leap_q      <= leap_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ref_day_q    <= ref_day_d;
    ref_month_q  <= ref_month_d;
    ref_year_q   <= ref_year_d;
    out_day_q    <= out_day_d;
    out_month_q  <= out_month_d;
    out_year_q   <= out_year_d;
    out_before_q <= out_before_d;
    out_equal_q  <= out_equal_d;
    out_after_q  <= out_after_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.cur_day   = out_day_q;
  assign rsp_o.cur_month = out_month_q;
  assign rsp_o.cur_year  = out_year_q;
  assign rsp_o.is_before = out_before_q;
  assign rsp_o.is_equal  = out_equal_q;
  assign rsp_o.is_after  = out_after_q;

endmodule

`default_nettype wire
